FILE: hdl/ohds_pkg.sv
// ohds_pkg: shared types and constants for the off-hook dialer sequencer.
// Used by every module in hdl/; depends on nothing.
package ohds_pkg;

  localparam int TICK_W  = 10;  // tick counters and timing registers
  localparam int DIGIT_W = 4;
  localparam int MODE_W  = 2;
  localparam int STORE_SLOTS = 16;  // hard cap on digits held (16 results per poll max)
  localparam int OQ_DEPTH = 4;
  localparam int OQ_LVL_W = 3;      // holds 0..OQ_DEPTH
  localparam int OQ_PTR_W = 2;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // register indexes (byte address / 4)
  localparam logic REG_OPEN_WINDOW    = 1'b0;
  localparam logic REG_BUFFER_TIMEOUT = 1'b1;

  localparam logic [TICK_W-1:0] TICKS_RESET = 10'd400;

  // mode codes as seen on mode_now
  localparam logic [MODE_W-1:0] CODE_WAITING   = 2'd0;
  localparam logic [MODE_W-1:0] CODE_OPEN      = 2'd1;
  localparam logic [MODE_W-1:0] CODE_BUFFERING = 2'd2;
  localparam logic [MODE_W-1:0] CODE_DIALING   = 2'd3;

  typedef enum logic [3:0] {
    MODE_WAITING   = 4'b0001,
    MODE_OPEN      = 4'b0010,
    MODE_BUFFERING = 4'b0100,
    MODE_DIALING   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic                line_relay;
    logic [MODE_W-1:0]   mode_now;
    logic                dial_valid;
    logic [DIGIT_W-1:0]  dial_digit;
    logic                last;
  } result_t;

  // relay and mode code after the poll, carried on every burst result
  typedef struct packed {
    logic              relay;
    logic [MODE_W-1:0] code;
  } line_state_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_WAITING:   c = CODE_WAITING;
      MODE_OPEN:      c = CODE_OPEN;
      MODE_BUFFERING: c = CODE_BUFFERING;
      MODE_DIALING:   c = CODE_DIALING;
      default:        c = CODE_WAITING;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/ohds_regs.sv
// ohds_regs: APB register file with the open window and buffer timeout.
// Depends on ohds_pkg.
module ohds_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ohds_pkg::APB_AW-1:0]   paddr,
  input  logic [ohds_pkg::APB_DW-1:0]   pwdata,
  output logic [ohds_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [ohds_pkg::TICK_W-1:0]   open_window_ticks,
  output logic [ohds_pkg::TICK_W-1:0]   buffer_timeout_ticks
);

  logic wr_en;
  logic idx;

  assign pready = 1'b1;
  assign idx    = paddr[2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_window_ticks    <= ohds_pkg::TICKS_RESET;
      buffer_timeout_ticks <= ohds_pkg::TICKS_RESET;
    end else if (wr_en) begin
      if (idx == ohds_pkg::REG_OPEN_WINDOW) begin
        open_window_ticks <= pwdata[ohds_pkg::TICK_W-1:0];
      end else begin
        buffer_timeout_ticks <= pwdata[ohds_pkg::TICK_W-1:0];
      end
    end
  end

  always_comb begin
    if (idx == ohds_pkg::REG_OPEN_WINDOW) begin
      prdata = {{(ohds_pkg::APB_DW-ohds_pkg::TICK_W){1'b0}}, open_window_ticks};
    end else begin
      prdata = {{(ohds_pkg::APB_DW-ohds_pkg::TICK_W){1'b0}}, buffer_timeout_ticks};
    end
  end

endmodule

FILE: hdl/ohds_ctrl.sv
// ohds_ctrl: per-poll mode logic, tick counters and store write requests.
// Depends on ohds_pkg; drives ohds_store and the output queue.
module ohds_ctrl #(
  parameter int MAX_COUNT    = 1000,
  parameter int CAP          = 16,
  parameter int CNT_W        = 5,
  parameter int ADDR_W       = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           poll,
  input  logic                           tick,
  input  logic                           hook_lifted,
  input  logic                           digit_valid,
  input  logic [ohds_pkg::DIGIT_W-1:0]   digit,
  input  logic [ohds_pkg::TICK_W-1:0]    open_window_ticks,
  input  logic [ohds_pkg::TICK_W-1:0]    buffer_timeout_ticks,
  output logic                           wr_en,
  output logic [ADDR_W-1:0]              wr_addr,
  output logic [ohds_pkg::DIGIT_W-1:0]   wr_data,
  output logic                           burst_start,
  output logic [CNT_W-1:0]               burst_len,
  output logic                           push,
  output ohds_pkg::result_t              push_res,
  output ohds_pkg::line_state_t          line_state
);

  localparam logic [ohds_pkg::TICK_W-1:0] CNT_MAX = ohds_pkg::TICK_W'(MAX_COUNT);
  localparam logic [CNT_W-1:0]            CAP_C   = CNT_W'(CAP);

  ohds_pkg::mode_t             mode, mode_next;
  logic [ohds_pkg::TICK_W-1:0] open_counter, open_counter_next;
  logic [ohds_pkg::TICK_W-1:0] idle_counter, idle_counter_next;
  logic [CNT_W-1:0]            digit_count, digit_count_next;
  logic                        relay_on, relay_on_next;
  logic                        echo;
  logic                        store_req;

  function automatic logic [ohds_pkg::TICK_W-1:0] sat_inc(logic [ohds_pkg::TICK_W-1:0] c);
    return (c < CNT_MAX) ? c + 1'b1 : c;
  endfunction

  always_comb begin
    mode_next         = mode;
    open_counter_next = tick ? sat_inc(open_counter) : open_counter;
    idle_counter_next = tick ? sat_inc(idle_counter) : idle_counter;
    digit_count_next  = digit_count;
    relay_on_next     = relay_on;
    echo              = 1'b0;
    store_req         = 1'b0;
    burst_len         = '0;

    case (mode)
      ohds_pkg::MODE_WAITING: begin
        if (hook_lifted) begin
          open_counter_next = '0;
          digit_count_next  = '0;
          mode_next         = ohds_pkg::MODE_OPEN;
          relay_on_next     = 1'b1;
        end
      end
      ohds_pkg::MODE_OPEN: begin
        if (open_counter_next < open_window_ticks) begin
          if (digit_valid) begin
            relay_on_next     = 1'b0;
            store_req         = 1'b1;
            idle_counter_next = '0;
            mode_next         = ohds_pkg::MODE_BUFFERING;
          end
        end else if (digit_valid) begin
          echo = 1'b1;
        end
      end
      ohds_pkg::MODE_BUFFERING: begin
        store_req = digit_valid;
      end
      ohds_pkg::MODE_DIALING: begin
        relay_on_next    = 1'b1;
        burst_len        = digit_count;
        digit_count_next = '0;
        mode_next        = ohds_pkg::MODE_OPEN;
      end
      default: begin
        mode_next = ohds_pkg::MODE_WAITING;
      end
    endcase

    // full store drops the digit and leaves the idle count running
    wr_en = store_req && (digit_count < CAP_C);
    if (wr_en) begin
      digit_count_next  = digit_count + 1'b1;
      idle_counter_next = '0;
    end

    if (mode == ohds_pkg::MODE_BUFFERING && idle_counter_next >= buffer_timeout_ticks) begin
      mode_next = ohds_pkg::MODE_DIALING;
    end

    if (mode != ohds_pkg::MODE_WAITING && !hook_lifted) begin
      relay_on_next = 1'b0;
      mode_next     = ohds_pkg::MODE_WAITING;
    end
  end

  assign wr_addr     = digit_count[ADDR_W-1:0];
  assign wr_data     = digit;
  assign burst_start = poll && (burst_len != '0);
  assign push        = poll && (burst_len == '0);

  always_comb begin
    push_res.line_relay = relay_on_next;
    push_res.mode_now   = ohds_pkg::mode_code(mode_next);
    push_res.dial_valid = echo;
    push_res.dial_digit = echo ? digit : '0;
    push_res.last       = 1'b1;
  end

  // registered state is the state after the last poll
  assign line_state.relay = relay_on;
  assign line_state.code  = ohds_pkg::mode_code(mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ohds_pkg::MODE_WAITING;
      open_counter <= '0;
      idle_counter <= '0;
      digit_count  <= '0;
      relay_on     <= 1'b0;
    end else if (poll) begin
      mode         <= mode_next;
      open_counter <= open_counter_next;
      idle_counter <= idle_counter_next;
      digit_count  <= digit_count_next;
      relay_on     <= relay_on_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (poll && wr_en) |=> (digit_count != '0 && digit_count <= CAP_C))
    else $error("digit count out of range after store");

endmodule

FILE: hdl/ohds_store.sv
// ohds_store: digit memory (registered read) and the burst reader that plays it out.
// Depends on ohds_pkg; feeds the output queue.
module ohds_store #(
  parameter int CAP    = 16,
  parameter int CNT_W  = 5,
  parameter int ADDR_W = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [ADDR_W-1:0]               wr_addr,
  input  logic [ohds_pkg::DIGIT_W-1:0]    wr_data,
  input  logic                            burst_start,
  input  logic [CNT_W-1:0]                burst_len,
  input  ohds_pkg::line_state_t           line_state,
  input  logic [ohds_pkg::OQ_LVL_W-1:0]   q_level,
  output logic                            busy_any,
  output logic                            push,
  output ohds_pkg::result_t               push_res
);

  logic [ohds_pkg::DIGIT_W-1:0] mem [CAP];
  logic [ohds_pkg::DIGIT_W-1:0] rd_data;

  logic                         busy;
  logic                         pending;
  logic                         pend_last;
  logic [CNT_W-1:0]             rd_idx;
  logic [CNT_W-1:0]             len;
  logic                         issue;
  logic                         issue_last;

  // issue only when the queue can take the read in flight plus this one
  assign issue      = busy && ((q_level + ohds_pkg::OQ_LVL_W'(pending))
                               < ohds_pkg::OQ_LVL_W'(ohds_pkg::OQ_DEPTH));
  assign issue_last = (rd_idx == len - 1'b1);

  // writes only happen on polls, which stall while a burst reads; no overlap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pending   <= 1'b0;
      pend_last <= 1'b0;
      rd_idx    <= '0;
      len       <= '0;
    end else begin
      pending <= issue;
      if (burst_start) begin
        busy   <= 1'b1;
        rd_idx <= '0;
        len    <= burst_len;
      end else if (issue) begin
        pend_last <= issue_last;
        rd_idx    <= rd_idx + 1'b1;
        if (issue_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign busy_any = busy || pending;
  assign push     = pending;

  always_comb begin
    push_res.line_relay = line_state.relay;
    push_res.mode_now   = line_state.code;
    push_res.dial_valid = 1'b1;
    push_res.dial_digit = rd_data;
    push_res.last       = pend_last;
  end

  assert property (@(posedge clk) disable iff (rst)
    burst_start |-> !busy_any)
    else $error("burst started while previous burst active");

  assert property (@(posedge clk) disable iff (rst)
    (issue && issue_last) |=> (!busy && pending && pend_last))
    else $error("burst did not close on its final read");

endmodule

FILE: hdl/ohds_outq.sv
// ohds_outq: small result queue between the sequencer and the output channel.
// Depends on ohds_pkg.
module ohds_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  ohds_pkg::result_t               push_res,
  input  logic                            pop,
  output logic                            not_empty,
  output logic                            full,
  output logic [ohds_pkg::OQ_LVL_W-1:0]   level,
  output ohds_pkg::result_t               head
);

  ohds_pkg::result_t            q [ohds_pkg::OQ_DEPTH];
  logic [ohds_pkg::OQ_PTR_W-1:0] rd_ptr;
  logic [ohds_pkg::OQ_PTR_W-1:0] wr_ptr;

  assign not_empty = (level != '0);
  assign full      = (level == ohds_pkg::OQ_LVL_W'(ohds_pkg::OQ_DEPTH));
  assign head      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("result pushed into full queue");

endmodule

FILE: hdl/offhook_dialer_sequencer.sv
// Off-hook dialer sequencer, top level: one poll request per cycle in while not stalled, results out.
// A status or echo result is pushed into the result queue in the cycle its poll is accepted.
// A dialing poll with n > 0 stored digits emits n results, one per cycle while the
// result queue has room, from the digit memory (registered read); polls stall while
// the burst reader reads and pushes, and longer while the output stalls.
// Otherwise one poll per cycle while the 4-entry result queue has room.
// Synchronous reset clears mode, counters and relay; registers return to 400; store unset.
module offhook_dialer_sequencer #(
  parameter int BUFFER_DEPTH = 16,
  parameter int MAX_COUNT    = 1000
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            tick,
  input  logic                            hook_lifted,
  input  logic                            digit_valid,
  input  logic [ohds_pkg::DIGIT_W-1:0]    digit,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            line_relay,
  output logic [ohds_pkg::MODE_W-1:0]     mode_now,
  output logic                            dial_valid,
  output logic [ohds_pkg::DIGIT_W-1:0]    dial_digit,
  output logic                            last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ohds_pkg::APB_AW-1:0]     paddr,
  input  logic [ohds_pkg::APB_DW-1:0]     pwdata,
  output logic [ohds_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int CAP    = (BUFFER_DEPTH < ohds_pkg::STORE_SLOTS) ? BUFFER_DEPTH
                                                                 : ohds_pkg::STORE_SLOTS;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;

  logic [ohds_pkg::TICK_W-1:0]  open_window_ticks;
  logic [ohds_pkg::TICK_W-1:0]  buffer_timeout_ticks;
  logic                         poll;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [ohds_pkg::DIGIT_W-1:0] wr_data;
  logic                         burst_start;
  logic [CNT_W-1:0]             burst_len;
  logic                         c_push, s_push, q_push;
  ohds_pkg::result_t            c_res, s_res, q_res, head;
  ohds_pkg::line_state_t        line_state;
  logic                         busy_any;
  logic                         q_full;
  logic [ohds_pkg::OQ_LVL_W-1:0] q_level;
  logic                         pop;

  assign in_stall = busy_any || q_full;
  assign poll     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  ohds_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .open_window_ticks, .buffer_timeout_ticks
  );

  ohds_ctrl #(
    .MAX_COUNT(MAX_COUNT),
    .CAP(CAP), .CNT_W(CNT_W), .ADDR_W(ADDR_W)
  ) u_ctrl (
    .clk, .rst, .poll, .tick, .hook_lifted, .digit_valid, .digit,
    .open_window_ticks, .buffer_timeout_ticks,
    .wr_en, .wr_addr, .wr_data, .burst_start, .burst_len,
    .push(c_push), .push_res(c_res), .line_state
  );

  ohds_store #(.CAP(CAP), .CNT_W(CNT_W), .ADDR_W(ADDR_W)) u_store (
    .clk, .rst,
    .wr_en(wr_en && poll), .wr_addr, .wr_data,
    .burst_start, .burst_len, .line_state, .q_level,
    .busy_any, .push(s_push), .push_res(s_res)
  );

  // polls are stalled while the burst reader pushes, so the two never collide
  assign q_push = c_push || s_push;
  assign q_res  = c_push ? c_res : s_res;

  ohds_outq u_outq (
    .clk, .rst, .push(q_push), .push_res(q_res), .pop,
    .not_empty(out_valid), .full(q_full), .level(q_level), .head
  );

  assign line_relay = head.line_relay;
  assign mode_now   = head.mode_now;
  assign dial_valid = head.dial_valid;
  assign dial_digit = head.dial_digit;
  assign last       = head.last;

endmodule

FILE: dv/tb_offhook_dialer_sequencer.sv
// Self-checking testbench for offhook_dialer_sequencer: directed and random poll
// requests, APB register writes, randomized valid/stall idling and a long output hold.
// Depends on hdl/ohds_pkg.sv and hdl/offhook_dialer_sequencer.sv.
`timescale 1ns / 100ps

module tb_offhook_dialer_sequencer;

  localparam int COUNT_MAX = 1000;
  localparam int STORE_CAP = 16;
  localparam int SETTLE_CYCLES = 24;  // longest burst plus read latency, with margin

  typedef struct packed {
    bit                         tick;
    bit                         hook;
    bit                         dv;
    bit [ohds_pkg::DIGIT_W-1:0] digit;
  } poll_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic tick = 1'b0;
  logic hook_lifted = 1'b0;
  logic digit_valid = 1'b0;
  logic [ohds_pkg::DIGIT_W-1:0] digit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic line_relay;
  logic [ohds_pkg::MODE_W-1:0] mode_now;
  logic dial_valid;
  logic [ohds_pkg::DIGIT_W-1:0] dial_digit;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ohds_pkg::APB_AW-1:0] paddr = '0;
  logic [ohds_pkg::APB_DW-1:0] pwdata = '0;
  logic [ohds_pkg::APB_DW-1:0] prdata;
  logic pready;

  offhook_dialer_sequencer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .tick(tick), .hook_lifted(hook_lifted), .digit_valid(digit_valid), .digit(digit),
    .out_valid(out_valid), .out_stall(out_stall),
    .line_relay(line_relay), .mode_now(mode_now), .dial_valid(dial_valid),
    .dial_digit(dial_digit), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // pending poll requests and the results they are due to produce
  poll_t             poll_q[$];
  ohds_pkg::result_t due_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int n_fail = 0;
  int n_planned = 0;
  int n_calls = 0;
  int n_settings = 0;
  int n_polls = 0;
  int n_results = 0;
  int n_dialed = 0;

  // dialer state as the testbench tracks it
  logic [ohds_pkg::TICK_W-1:0]  cfg_open = ohds_pkg::TICKS_RESET;
  logic [ohds_pkg::TICK_W-1:0]  cfg_timeout = ohds_pkg::TICKS_RESET;
  logic [ohds_pkg::MODE_W-1:0]  cur_mode = ohds_pkg::CODE_WAITING;
  logic [ohds_pkg::TICK_W-1:0]  open_cnt = '0;
  logic [ohds_pkg::TICK_W-1:0]  idle_cnt = '0;
  logic [ohds_pkg::DIGIT_W-1:0] digit_mem [STORE_CAP];
  int                           n_stored = 0;
  logic                         relay = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [ohds_pkg::TICK_W-1:0] sat_inc(logic [ohds_pkg::TICK_W-1:0] c);
    return (c < COUNT_MAX) ? c + 1'b1 : c;
  endfunction

  task automatic store_digit(input logic [ohds_pkg::DIGIT_W-1:0] d);
    if (n_stored < STORE_CAP) begin
      digit_mem[n_stored] = d;
      n_stored++;
      idle_cnt = '0;
    end
  endtask

  // one accepted poll: update the tracked state, queue the results it causes
  task automatic advance_dialer(input poll_t p);
    logic                         echo;
    int                           nb;
    logic [ohds_pkg::DIGIT_W-1:0] burst [STORE_CAP];
    ohds_pkg::result_t            r;
    echo = 1'b0;
    nb = 0;
    if (p.tick) begin
      idle_cnt = sat_inc(idle_cnt);
      open_cnt = sat_inc(open_cnt);
    end
    case (cur_mode)
      ohds_pkg::CODE_WAITING: begin
        if (p.hook) begin
          open_cnt = '0;
          n_stored = 0;
          cur_mode = ohds_pkg::CODE_OPEN;
          relay = 1'b1;
        end
      end
      ohds_pkg::CODE_OPEN: begin
        if (open_cnt < cfg_open) begin
          if (p.dv) begin
            relay = 1'b0;
            store_digit(p.digit);
            idle_cnt = '0;
            cur_mode = ohds_pkg::CODE_BUFFERING;
          end
        end else if (p.dv) begin
          echo = 1'b1;
        end
        if (!p.hook) begin
          relay = 1'b0;
          cur_mode = ohds_pkg::CODE_WAITING;
        end
      end
      ohds_pkg::CODE_BUFFERING: begin
        if (p.dv) store_digit(p.digit);
        if (idle_cnt >= cfg_timeout) cur_mode = ohds_pkg::CODE_DIALING;
        if (!p.hook) begin
          relay = 1'b0;
          cur_mode = ohds_pkg::CODE_WAITING;
        end
      end
      default: begin
        relay = 1'b1;
        nb = n_stored;
        for (int i = 0; i < nb; i++) burst[i] = digit_mem[i];
        n_stored = 0;
        cur_mode = ohds_pkg::CODE_OPEN;
        if (!p.hook) begin
          relay = 1'b0;
          cur_mode = ohds_pkg::CODE_WAITING;
        end
      end
    endcase
    r.line_relay = relay;
    r.mode_now = cur_mode;
    r.last = 1'b1;
    if (echo) begin
      r.dial_valid = 1'b1;
      r.dial_digit = p.digit;
      due_results.push_back(r);
    end else if (nb > 0) begin
      for (int i = 0; i < nb; i++) begin
        r.dial_valid = 1'b1;
        r.dial_digit = burst[i];
        r.last = (i == nb - 1);
        due_results.push_back(r);
      end
    end else begin
      r.dial_valid = 1'b0;
      r.dial_digit = '0;
      due_results.push_back(r);
    end
  endtask

  task automatic cmp(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  task automatic check_result(input ohds_pkg::result_t got);
    ohds_pkg::result_t want;
    if (due_results.size() == 0) begin
      $error("result %h arrived with nothing pending", got);
      n_fail++;
    end else begin
      want = due_results.pop_front();
      cmp("line_relay", 4'(want.line_relay), 4'(got.line_relay));
      cmp("mode_now", 4'(want.mode_now), 4'(got.mode_now));
      cmp("dial_valid", 4'(want.dial_valid), 4'(got.dial_valid));
      cmp("dial_digit", want.dial_digit, got.dial_digit);
      cmp("last", 4'(want.last), 4'(got.last));
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_polls
    poll_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        p = poll_q.pop_front();
        in_valid <= 1'b1;
        tick <= p.tick;
        hook_lifted <= p.hook;
        digit_valid <= p.dv;
        digit <= p.digit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure; a long hold takes priority over random stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    poll_t             p;
    ohds_pkg::result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        p.tick = tick;
        p.hook = hook_lifted;
        p.dv = digit_valid;
        p.digit = digit;
        n_polls++;
        advance_dialer(p);
      end
      if (out_valid && !out_stall) begin
        got.line_relay = line_relay;
        got.mode_now = mode_now;
        got.dial_valid = dial_valid;
        got.dial_digit = dial_digit;
        got.last = last;
        n_results++;
        if (dial_valid === 1'b1) n_dialed++;
        check_result(got);
      end
    end
  end

  task automatic add_poll(input bit t, input bit h, input bit dv,
                          input bit [ohds_pkg::DIGIT_W-1:0] d);
    poll_t p;
    p.tick = t;
    p.hook = h;
    p.dv = dv;
    p.digit = d;
    poll_q.push_back(p);
    n_planned++;
  endtask

  function automatic bit rnd_bit();
    return bit'($urandom_range(1));
  endfunction

  function automatic bit [ohds_pkg::DIGIT_W-1:0] rnd_digit();
    return ohds_pkg::DIGIT_W'($urandom_range(15));
  endfunction

  // one call: hang up, lift, digits, dial only if the timeout is short, then 0-3 extras
  task automatic plan_call();
    int ndig;
    int cut;
    int waited;
    bit t;
    n_calls++;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(2, 6))
        add_poll(rnd_bit(), rnd_bit(), rnd_bit(), rnd_digit());
      return;
    end
    add_poll(rnd_bit(), 1'b0, rnd_bit(), rnd_digit());
    add_poll(rnd_bit(), 1'b1, 1'b0, rnd_digit());
    ndig = ($urandom_range(99) < 25) ? $urandom_range(14, 20) : $urandom_range(1, 6);
    cut = ($urandom_range(99) < 15) ? $urandom_range(1, ndig) : 0;
    for (int k = 1; k <= ndig; k++) begin
      if (k == cut) begin
        // caller hangs up mid-number
        add_poll(rnd_bit(), 1'b0, 1'b1, rnd_digit());
        return;
      end
      add_poll((k == 1) ? 1'b0 : rnd_bit(), 1'b1, 1'b1, rnd_digit());
    end
    if (cfg_timeout <= 12) begin
      waited = 0;
      while (waited < cfg_timeout) begin
        t = ($urandom_range(3) != 0);
        add_poll(t, 1'b1, 1'b0, rnd_digit());
        waited += int'(t);
      end
      add_poll(rnd_bit(), $urandom_range(9) != 0, rnd_bit(), rnd_digit());
    end else begin
      add_poll(rnd_bit(), 1'b0, rnd_bit(), rnd_digit());
    end
    repeat ($urandom_range(0, 3))
      add_poll(rnd_bit(), 1'b1, rnd_bit(), rnd_digit());
  endtask

  task automatic plan_random(input int n);
    int start;
    start = n_planned;
    while (n_planned - start < n) plan_call();
  endtask

  task automatic settle();
    while (poll_q.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [ohds_pkg::TICK_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(ohds_pkg::APB_DW - ohds_pkg::TICK_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ohds_pkg::REG_OPEN_WINDOW) cfg_open = v;
    else cfg_timeout = v;
  endtask

  task automatic start_phase(input int send_pct, input int recv_pct,
                             input logic [ohds_pkg::TICK_W-1:0] win,
                             input logic [ohds_pkg::TICK_W-1:0] tmo);
    settle();
    cfg_write(ohds_pkg::REG_OPEN_WINDOW, win);
    cfg_write(ohds_pkg::REG_BUFFER_TIMEOUT, tmo);
    n_settings++;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values: digit inside the long window, then hang up
    add_poll(1'b0, 1'b1, 1'b0, 4'd0);
    add_poll(1'b1, 1'b1, 1'b1, 4'd8);
    add_poll(1'b0, 1'b0, 1'b0, 4'd0);

    start_phase(0, 0, 10'd3, 10'd2);
    add_poll(1'b0, 1'b0, 1'b1, 4'd5);   // digit while waiting is dropped
    add_poll(1'b1, 1'b1, 1'b0, 4'd0);   // off hook
    add_poll(1'b0, 1'b1, 1'b1, 4'd0);   // first digit in window
    add_poll(1'b0, 1'b1, 1'b1, 4'd15);
    add_poll(1'b1, 1'b1, 1'b1, 4'd9);
    add_poll(1'b1, 1'b1, 1'b0, 4'd0);
    add_poll(1'b1, 1'b1, 1'b0, 4'd0);   // timeout
    add_poll(1'b0, 1'b1, 1'b0, 4'd0);   // burst of three
    add_poll(1'b0, 1'b1, 1'b1, 4'd10);  // window closed: echo
    add_poll(1'b1, 1'b0, 1'b0, 4'd0);   // hang up while line open
    add_poll(1'b0, 1'b1, 1'b0, 4'd0);
    add_poll(1'b0, 1'b1, 1'b1, 4'd7);
    add_poll(1'b1, 1'b0, 1'b1, 4'd3);   // hang up while buffering
    add_poll(1'b0, 1'b1, 1'b0, 4'd0);
    add_poll(1'b0, 1'b1, 1'b1, 4'd12);
    add_poll(1'b1, 1'b1, 1'b0, 4'd0);
    add_poll(1'b1, 1'b1, 1'b0, 4'd0);
    add_poll(1'b0, 1'b0, 1'b1, 4'd4);   // hang up while dialing, digit dropped
    add_poll(1'b1, 1'b0, 1'b0, 4'd0);
    plan_random(15);

    start_phase(71, 0, 10'd6, 10'd0);
    plan_random(20);

    // counters saturate below these, so window never closes and timeout never fires
    start_phase(0, 71, 10'd1023, 10'd1023);
    plan_random(20);

    start_phase(14, 14, 10'd0, 10'd5);
    plan_random(15);

    start_phase(0, 0, 10'd1000, 10'd1);
    hold_len = 150;
    plan_random(15);

    settle();
    $display("checked %0d polls from %0d calls under %0d register settings",
             n_polls, n_calls, n_settings);
    $display("%0d results compared, %0d of them dialed digits", n_results, n_dialed);
    if (n_fail == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
